// ===== rtl/bpa_pkg.sv =====
// Package for the buffer pool allocator: request and response word types,
// action and status codes, and default sizes. No dependencies.

package bpa_pkg;

  localparam int MAX_SLOTS_DEF = 32;

  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 5;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 6;
  localparam int COUNT_W  = 6;

  localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 6'd32;

  // Request actions.
  localparam logic [ACTION_W-1:0] ACT_ALLOC_FIRST = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC_INDEX = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE        = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FREE_ALL    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_LOCK        = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_UNLOCK      = 3'd5;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOFREE  = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  buffer_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  slot_index;
    logic [COUNT_W-1:0]  in_use_count;
  } rsp_t;

endpackage

// ===== rtl/buffer_pool_allocator.sv =====
// Buffer pool allocator. A request word passes the input register, then one
// decision stage into the result register, where its response word is registered.
// Throughput: one request word per cycle while the receiver takes responses;
// the used and locked bits are updated as the response is registered.
// Reset clears every used and locked bit and the count at once, and sets pool_size to 32.

module buffer_pool_allocator #(
  parameter int MAX_SLOTS = bpa_pkg::MAX_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bpa_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  bpa_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output bpa_pkg::rsp_t              rsp
);
  import bpa_pkg::*;

  // Request word waiting in the input register.
  logic held_valid;
  req_t held;

  // High when the held request is decided and its response registered.
  logic advance;

  rsp_t rsp_next;

  // The input register parts the sender from the decision logic, so a new
  // request word can enter while the previous one is being decided.
  bpa_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  // The core holds the per-slot state. The lowest free slot comes from a
  // priority encoder over the free map, so each request is decided in
  // combinational logic and the next request sees the updated state.
  bpa_core #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fire     (advance),
    .req      (held),
    .rsp_next (rsp_next)
  );

  // The result register holds a response word while the receiver stalls;
  // the state only changes when the response is actually loaded.
  bpa_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .rsp_next   (rsp_next),
    .advance    (advance),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

// ===== rtl/bpa_in_stage.sv =====
// Input register of the buffer pool allocator: captures one request word.
// Depends on bpa_pkg for the request word type.

module bpa_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bpa_pkg::req_t req,
  input  logic          advance,
  output logic          held_valid,
  output bpa_pkg::req_t held
);
  import bpa_pkg::*;

  logic accept;

  // The held word leaves when the decision stage takes it, so a new word can
  // enter in the same cycle.
  assign req_stall = held_valid && !advance;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= req;
    end
  end

endmodule

// ===== rtl/bpa_core.sv =====
// Slot state and decision logic of the buffer pool allocator: used and locked
// bits, used count, pool size register. Depends on bpa_pkg.

module bpa_core #(
  parameter int MAX_SLOTS = bpa_pkg::MAX_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bpa_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       fire,
  input  bpa_pkg::req_t              req,
  output bpa_pkg::rsp_t              rsp_next
);
  import bpa_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  logic [MAX_SLOTS-1:0] used;
  logic [MAX_SLOTS-1:0] used_next;
  logic [MAX_SLOTS-1:0] locked;
  logic [MAX_SLOTS-1:0] locked_next;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [SIZE_W-1:0]    pool_size;

  logic [MAX_SLOTS-1:0] free_map;
  logic                 any_free;
  logic [IDX_W-1:0]     first_free;
  logic [IDX_W-1:0]     ix;
  logic                 idx_ok;
  logic [STATUS_W-1:0]  status;
  logic [INDEX_W-1:0]   slot;

  // Free map limited to the slots in service, and its lowest set bit.
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      free_map[i] = !used[i] && (i < int'(pool_size));
    end
    any_free   = |free_map;
    first_free = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        first_free = IDX_W'(i);
      end
    end
  end

  assign ix     = IDX_W'(req.buffer_index);
  assign idx_ok = (int'(req.buffer_index) < int'(pool_size)) &&
                  (int'(req.buffer_index) < MAX_SLOTS);

  always_comb begin
    used_next   = used;
    locked_next = locked;
    count_next  = count;
    status      = ST_INVALID;
    slot        = '0;
    case (req.action)
      ACT_ALLOC_FIRST: begin
        if (any_free) begin
          used_next[first_free] = 1'b1;
          count_next            = count + CNT_W'(1);
          status                = ST_OK;
          slot                  = INDEX_W'(first_free);
        end else begin
          status = ST_NOFREE;
        end
      end
      ACT_ALLOC_INDEX: begin
        if (!idx_ok) begin
          status = ST_INVALID;
        end else if (used[ix] || locked[ix]) begin
          status = ST_BUSY;
        end else begin
          used_next[ix] = 1'b1;
          count_next    = count + CNT_W'(1);
          status        = ST_OK;
          slot          = req.buffer_index;
        end
      end
      ACT_FREE: begin
        if (!idx_ok) begin
          status = ST_INVALID;
        end else if (locked[ix]) begin
          status = ST_BUSY;
        end else begin
          // Freeing a slot that is not in use succeeds and keeps the count.
          if (used[ix]) begin
            used_next[ix] = 1'b0;
            if (count != '0) begin
              count_next = count - CNT_W'(1);
            end
          end
          status = ST_OK;
          slot   = req.buffer_index;
        end
      end
      ACT_FREE_ALL: begin
        used_next   = '0;
        locked_next = '0;
        count_next  = '0;
        status      = ST_OK;
      end
      ACT_LOCK, ACT_UNLOCK: begin
        if (!idx_ok) begin
          status = ST_INVALID;
        end else begin
          locked_next[ix] = (req.action == ACT_LOCK);
          status          = ST_OK;
          slot            = req.buffer_index;
        end
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
  end

  always_comb begin
    rsp_next.status       = status;
    rsp_next.slot_index   = slot;
    rsp_next.in_use_count = COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      locked <= '0;
      count  <= '0;
    end else if (fire) begin
      used   <= used_next;
      locked <= locked_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= POOL_SIZE_RST;
    end else if (cfg_we) begin
      pool_size <= cfg_data;
    end
  end

endmodule

// ===== rtl/bpa_out_stage.sv =====
// Result register of the buffer pool allocator: holds one response word
// until the receiver takes it. Depends on bpa_pkg for the response type.

module bpa_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          held_valid,
  input  bpa_pkg::rsp_t rsp_next,
  output logic          advance,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bpa_pkg::rsp_t rsp
);
  import bpa_pkg::*;

  // A new word loads when the register is empty or its word leaves now.
  assign advance = held_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule
